/* rtl/ssd_pkg.sv */
// Package for the seven-segment scan driver: command codes, sequencer state,
// and the font, anode and digit-group tables.
// No dependencies.
package ssd_pkg;

  localparam int unsigned NumDigits = 12;
  localparam int unsigned FontSize  = 42;

  typedef logic [3:0] pos_t;
  typedef logic [7:0] code_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_NUMBER = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_POINT  = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SPLIT
  } state_t;

  localparam code_t CharZero   = 8'h30;
  localparam code_t AnodeBlank = 8'hFF;
  localparam pos_t  LastPhase  = 4'd11;

  function automatic logic [6:0] font_seg(input code_t code);
    logic [6:0] seg;
    seg = 7'h00;
    unique case (code)
      8'd0:  seg = 7'h3F;
      8'd1:  seg = 7'h0C;
      8'd2:  seg = 7'h6B;
      8'd3:  seg = 7'h6D;
      8'd4:  seg = 7'h5C;
      8'd5:  seg = 7'h75;
      8'd6:  seg = 7'h77;
      8'd7:  seg = 7'h2C;
      8'd8:  seg = 7'h7F;
      8'd9:  seg = 7'h7D;
      8'd17: seg = 7'h7E;
      8'd18: seg = 7'h57;
      8'd19: seg = 7'h33;
      8'd20: seg = 7'h4F;
      8'd21: seg = 7'h73;
      8'd22: seg = 7'h72;
      8'd23: seg = 7'h37;
      8'd24: seg = 7'h5E;
      8'd25: seg = 7'h04;
      8'd26: seg = 7'h0D;
      8'd28: seg = 7'h13;
      8'd30: seg = 7'h46;
      8'd31: seg = 7'h47;
      8'd32: seg = 7'h7A;
      8'd33: seg = 7'h7C;
      8'd34: seg = 7'h42;
      8'd36: seg = 7'h53;
      8'd37: seg = 7'h07;
      8'd41: seg = 7'h5D;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [7:0] anode_sel(input logic [2:0] ph);
    logic [7:0] a;
    unique case (ph)
      3'd0: a = 8'h80;
      3'd1: a = 8'h40;
      3'd2: a = 8'h08;
      3'd3: a = 8'h10;
      3'd4: a = 8'h20;
      3'd5: a = 8'h04;
      3'd6: a = 8'h02;
      default: a = 8'h01;
    endcase
    return a;
  endfunction

  function automatic pos_t group_start(input logic [1:0] grp);
    pos_t s;
    unique case (grp)
      2'd0: s = 4'd0;
      2'd1: s = 4'd2;
      2'd2: s = 4'd5;
      default: s = 4'd8;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] group_len(input logic [1:0] grp);
    logic [2:0] l;
    unique case (grp)
      2'd0: l = 3'd2;
      2'd1, 2'd2: l = 3'd3;
      default: l = 3'd4;
    endcase
    return l;
  endfunction

endpackage

/* rtl/ssd_div10.sv */
// Divide-by-ten unit shared by every step of the decimal split.
// Uses a reciprocal multiply; no package dependencies beyond widths.
module ssd_div10 (
  input  logic [15:0] dividend,
  output logic [15:0] quot,
  output logic [3:0]  rem
);
  logic [31:0] prod;
  logic [12:0] q;
  logic [16:0] q_times10;
  logic [16:0] diff;

  // 0xCCCD / 2^19 is exact for every 16-bit dividend.
  assign prod      = dividend * 16'hCCCD;
  assign q         = prod[31:19];
  assign q_times10 = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
  assign diff      = {1'b0, dividend} - q_times10;
  assign quot      = {3'b000, q};
  assign rem       = diff[3:0];
endmodule

/* rtl/seven_segment_scan_driver_unit.sv */
// Seven-segment scan driver: a tick gives its refresh word in the cycle after the beat,
// marked by out_valid for one cycle. Tick, text and point beats never raise busy.
// A set-number beat splits into decimal digits through one divide-by-ten unit,
// one digit per cycle: busy stays high while the group's digits are written.
// The receiver cannot stall. Synchronous active-low reset clears the sequencer state,
// digits, points, phase and the output strobe.
module seven_segment_scan_driver_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ssd_pkg::cmd_t       in_cmd,
  input  logic [1:0]          in_group_sel,
  input  logic [15:0]         in_number_value,
  input  logic [7:0]          in_char0,
  input  logic [7:0]          in_char1,
  input  logic [7:0]          in_char2,
  input  logic [7:0]          in_char3,
  input  logic [7:0]          in_digit_pos,
  input  logic                in_point_on,
  output logic                out_valid,
  output logic [15:0]         out_shift_word,
  output logic [3:0]          out_extra_enables,
  output logic [3:0]          out_scan_phase
);
  import ssd_pkg::*;

  state_t state_r, state_nxt;
  code_t  digit_codes_r [NumDigits];
  logic [NumDigits-1:0] point_bits_r;
  pos_t   phase_r;
  logic [15:0] num_r;
  pos_t   pos_r;
  logic [1:0] cnt_r;
  logic   out_valid_r;
  logic [15:0] out_word_r;
  logic [3:0]  out_en_r;
  pos_t   out_phase_r;

  logic   accept;
  logic   split_last;
  logic [15:0] quot;
  logic [3:0]  rem;
  pos_t   g_start;
  logic [2:0] g_len;
  pos_t   ph_nxt;
  code_t  chars [4];
  pos_t   pt_bit;

  ssd_div10 u_div (
    .dividend (num_r),
    .quot     (quot),
    .rem      (rem)
  );

  assign g_start  = group_start(in_group_sel);
  assign g_len    = group_len(in_group_sel);
  assign ph_nxt   = (phase_r == LastPhase) ? 4'd0 : phase_r + 4'd1;
  assign chars[0] = in_char0;
  assign chars[1] = in_char1;
  assign chars[2] = in_char2;
  assign chars[3] = in_char3;
  assign pt_bit   = g_start + {1'b0, g_len} - 4'd1 - in_digit_pos[3:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_cmd == CMD_NUMBER) state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (cnt_r == 2'd0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy       = 1'b0;
    split_last = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SPLIT: begin
        busy       = 1'b1;
        split_last = (cnt_r == 2'd0);
      end
      default: busy = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      point_bits_r <= '0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NumDigits; i++) digit_codes_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= accept && (in_cmd == CMD_TICK);
      if (state_r == ST_SPLIT) begin
        // Lowest decimal digit goes rightmost, then walk left.
        digit_codes_r[pos_r] <= {4'd0, rem};
      end
      if (accept) begin
        unique case (in_cmd)
          CMD_TICK: begin
            phase_r <= ph_nxt;
          end
          CMD_NUMBER: ;
          CMD_TEXT: begin
            for (int i = 0; i < 4; i++) begin
              if (3'(i) < g_len) digit_codes_r[g_start + 4'(i)] <= chars[i] - CharZero;
            end
          end
          CMD_POINT: begin
            if (in_digit_pos < {5'd0, g_len}) point_bits_r[pt_bit] <= in_point_on;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_NUMBER) begin
      num_r <= in_number_value;
      pos_r <= g_start + {1'b0, g_len} - 4'd1;
      cnt_r <= 2'(g_len - 3'd1);
    end else if (state_r == ST_SPLIT && !split_last) begin
      num_r <= quot;
      pos_r <= pos_r - 4'd1;
      cnt_r <= cnt_r - 2'd1;
    end
    if (accept && in_cmd == CMD_TICK) begin
      out_word_r[15:8] <= (ph_nxt < 4'd8) ? ~anode_sel(ph_nxt[2:0]) : AnodeBlank;
      out_word_r[7]    <= point_bits_r[ph_nxt];
      out_word_r[6:0]  <= (digit_codes_r[ph_nxt] < code_t'(FontSize)) ?
                          font_seg(digit_codes_r[ph_nxt]) : 7'h00;
      out_en_r         <= (ph_nxt < 4'd8) ? 4'd0 : (4'd1 << ph_nxt[1:0]);
      out_phase_r      <= ph_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_shift_word    = out_word_r;
  assign out_extra_enables = out_en_r;
  assign out_scan_phase    = out_phase_r;
endmodule

/* rtl/ssd_checker.sv */
// Port-level checks for the seven-segment scan driver, bound to the top level.
// Depends on ssd_pkg for command codes and display constants.
module ssd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input ssd_pkg::cmd_t in_cmd,
  input logic          out_valid,
  input logic [15:0]   out_shift_word,
  input logic [3:0]    out_extra_enables,
  input logic [3:0]    out_scan_phase
);
  import ssd_pkg::*;

  a_tick_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_TICK |=> out_valid)
    else $error("tick beat produced no refresh word");

  a_beat_only_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_cmd == CMD_TICK))
    else $error("refresh word without a tick");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scan_phase <= LastPhase)
    else $error("scan phase out of range");

  a_enables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scan_phase < 4'd8) ?
      (out_extra_enables == 4'd0 && $onehot(~out_shift_word[15:8])) :
      ($onehot(out_extra_enables) && out_shift_word[15:8] == AnodeBlank))
    else $error("anode byte and extra enables disagree with phase");

  a_number_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_NUMBER |=> busy)
    else $error("set number did not hold off the next beat");
endmodule

bind seven_segment_scan_driver_unit ssd_checker u_ssd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_cmd            (in_cmd),
  .out_valid         (out_valid),
  .out_shift_word    (out_shift_word),
  .out_extra_enables (out_extra_enables),
  .out_scan_phase    (out_scan_phase)
);

/* verif/seven_segment_scan_driver_unit_tb.sv */
// Self-checking testbench for seven_segment_scan_driver_unit: directed and random command beats
// with bursty start timing, checked against an in-bench model of the digit store and scan phase.
// Depends on rtl/ssd_pkg.sv and rtl/seven_segment_scan_driver_unit.sv.
module seven_segment_scan_driver_unit_tb;
  import ssd_pkg::*;

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  grp;
    logic [15:0] num;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic [7:0]  pos;
    logic        on;
  } display_beat_t;

  typedef struct packed {
    logic [15:0] shift_word;
    logic [3:0]  extra_en;
    logic [3:0]  phase;
  } refresh_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        in_cmd = CMD_TICK;
  logic [1:0]  in_group_sel = '0;
  logic [15:0] in_number_value = '0;
  logic [7:0]  in_char0 = '0;
  logic [7:0]  in_char1 = '0;
  logic [7:0]  in_char2 = '0;
  logic [7:0]  in_char3 = '0;
  logic [7:0]  in_digit_pos = '0;
  logic        in_point_on = 1'b0;
  logic        out_valid;
  logic [15:0] out_shift_word;
  logic [3:0]  out_extra_enables;
  logic [3:0]  out_scan_phase;

  seven_segment_scan_driver_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_group_sel      (in_group_sel),
    .in_number_value   (in_number_value),
    .in_char0          (in_char0),
    .in_char1          (in_char1),
    .in_char2          (in_char2),
    .in_char3          (in_char3),
    .in_digit_pos      (in_digit_pos),
    .in_point_on       (in_point_on),
    .out_valid         (out_valid),
    .out_shift_word    (out_shift_word),
    .out_extra_enables (out_extra_enables),
    .out_scan_phase    (out_scan_phase)
  );

  // Segment patterns by font index; gaps in the character set are blank.
  logic [6:0] seg_font [42] = '{
    7'h3F, 7'h0C, 7'h6B, 7'h6D, 7'h5C, 7'h75, 7'h77, 7'h2C, 7'h7F, 7'h7D,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h7E, 7'h57, 7'h33, 7'h4F, 7'h73, 7'h72, 7'h37, 7'h5E, 7'h04, 7'h0D,
    7'h00, 7'h13, 7'h00, 7'h46, 7'h47, 7'h7A, 7'h7C, 7'h42, 7'h00, 7'h53, 7'h07,
    7'h00, 7'h00, 7'h00, 7'h5D
  };
  logic [7:0] anode_pattern [8] = '{8'h80, 8'h40, 8'h08, 8'h10, 8'h20, 8'h04, 8'h02, 8'h01};
  int unsigned grp_first [4] = '{0, 2, 5, 8};
  int unsigned grp_size [4] = '{2, 3, 3, 4};

  logic [7:0]  shadow_codes [12];
  logic [11:0] shadow_points = '0;
  logic [3:0]  shadow_phase = '0;

  display_beat_t pending_beats [$];
  refresh_word_t refresh_words_due [$];
  int            n_fail = 0;
  bit            beat_taken = 1'b0;
  int            burst_left = 1;
  int            gap_left = 0;
  display_beat_t taken_beat;
  refresh_word_t due_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (shadow_codes[i]) shadow_codes[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic display_beat_t make_beat(cmd_t cmd, logic [1:0] grp, logic [15:0] num,
                                              logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                              logic [7:0] c3, logic [7:0] pos, logic on);
    display_beat_t b;
    b.cmd = cmd;
    b.grp = grp;
    b.num = num;
    b.c0  = c0;
    b.c1  = c1;
    b.c2  = c2;
    b.c3  = c3;
    b.pos = pos;
    b.on  = on;
    return b;
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h30, 8'h5A));
    return 8'($urandom);
  endfunction

  // Unused fields always carry noise so the block is seen to ignore them.
  function automatic display_beat_t random_display_beat();
    display_beat_t b;
    int unsigned   pick;
    b = make_beat(CMD_TICK, 2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      b.cmd = CMD_TICK;
    end else if (pick < 63) begin
      b.cmd = CMD_NUMBER;
      if ($urandom_range(0, 3) == 0) b.num = 16'($urandom_range(0, 99));
    end else if (pick < 81) begin
      b.cmd = CMD_TEXT;
      b.c0 = random_char();
      b.c1 = random_char();
      b.c2 = random_char();
      b.c3 = random_char();
    end else begin
      b.cmd = CMD_POINT;
      if ($urandom_range(0, 4) != 0) b.pos = 8'($urandom_range(0, 4));
    end
    return b;
  endfunction

  // Applies one accepted beat to the shadow display and queues the refresh word a tick makes.
  function automatic void apply_display_beat(display_beat_t b);
    int unsigned   first;
    int unsigned   size;
    int unsigned   v;
    int unsigned   ph;
    logic [7:0]    chars [4];
    logic [6:0]    seg;
    refresh_word_t w;
    first = grp_first[b.grp];
    size  = grp_size[b.grp];
    chars = '{b.c0, b.c1, b.c2, b.c3};
    case (b.cmd)
      CMD_NUMBER: begin
        v = b.num;
        for (int i = size; i > 0; i--) begin
          shadow_codes[first + i - 1] = 8'(v % 10);
          v = v / 10;
        end
      end
      CMD_TEXT: begin
        for (int i = 0; i < size; i++) shadow_codes[first + i] = chars[i] - CharZero;
      end
      CMD_POINT: begin
        if (b.pos < size) shadow_points[first + size - 1 - b.pos] = b.on;
      end
      default: begin
        ph = shadow_phase + 1;
        if (ph >= 12) ph = 0;
        shadow_phase = 4'(ph);
        seg = (shadow_codes[ph] < 42) ? seg_font[shadow_codes[ph]] : 7'h00;
        if (ph < 8) begin
          w.shift_word[15:8] = ~anode_pattern[ph];
          w.extra_en = 4'h0;
        end else begin
          w.shift_word[15:8] = AnodeBlank;
          w.extra_en = 4'(1 << (ph - 8));
        end
        w.shift_word[7:0] = {shadow_points[ph], seg};
        w.phase = 4'(ph);
        refresh_words_due.push_back(w);
      end
    endcase
  endfunction

  // Sender: holds an offered beat until it is taken, otherwise works in random bursts.
  always @(negedge clk) begin
    if (rst_n && !(start && !beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left != 0 || pending_beats.size() == 0) begin
        if (gap_left != 0) gap_left--;
        start <= 1'b0;
      end else begin
        in_cmd          <= pending_beats[0].cmd;
        in_group_sel    <= pending_beats[0].grp;
        in_number_value <= pending_beats[0].num;
        in_char0        <= pending_beats[0].c0;
        in_char1        <= pending_beats[0].c1;
        in_char2        <= pending_beats[0].c2;
        in_char3        <= pending_beats[0].c3;
        in_digit_pos    <= pending_beats[0].pos;
        in_point_on     <= pending_beats[0].on;
        start           <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Results at this edge were caused by earlier beats, so they are checked first.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (refresh_words_due.size() == 0) begin
          $error("unexpected refresh word %h, phase %0d", out_shift_word, out_scan_phase);
          n_fail++;
        end else begin
          due_word = refresh_words_due.pop_front();
          if (out_shift_word !== due_word.shift_word) begin
            $error("out_shift_word: expected %h, got %h", due_word.shift_word, out_shift_word);
            n_fail++;
          end
          if (out_extra_enables !== due_word.extra_en) begin
            $error("out_extra_enables: expected %h, got %h", due_word.extra_en,
                   out_extra_enables);
            n_fail++;
          end
          if (out_scan_phase !== due_word.phase) begin
            $error("out_scan_phase: expected %0d, got %0d", due_word.phase, out_scan_phase);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        taken_beat = pending_beats.pop_front();
        apply_display_beat(taken_beat);
        beat_taken = 1'b1;
      end
    end
  end

  initial begin
    pending_beats.push_back(make_beat(CMD_TICK, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0));
    // Font extremes: last valid index, first index past the table, and wrapped characters.
    pending_beats.push_back(make_beat(CMD_TEXT, 2'd3, 16'hFFFF, 8'h59, 8'h5A, 8'h00, 8'hFF,
                                      8'hFF, 1'b1));
    pending_beats.push_back(make_beat(CMD_TEXT, 2'd0, '0, 8'h30, 8'h39, 8'hFF, 8'hFF,
                                      '0, 1'b0));
    pending_beats.push_back(make_beat(CMD_NUMBER, 2'd1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                      8'hFF, 1'b1));
    pending_beats.push_back(make_beat(CMD_NUMBER, 2'd2, 16'h0000, '0, '0, '0, '0, '0, 1'b0));
    pending_beats.push_back(make_beat(CMD_POINT, 2'd0, '0, '0, '0, '0, '0, 8'd0, 1'b1));
    pending_beats.push_back(make_beat(CMD_POINT, 2'd3, '0, '0, '0, '0, '0, 8'd3, 1'b1));
    pending_beats.push_back(make_beat(CMD_POINT, 2'd1, '0, '0, '0, '0, '0, 8'd3, 1'b1));
    pending_beats.push_back(make_beat(CMD_POINT, 2'd3, '0, '0, '0, '0, '0, 8'd255, 1'b1));
    pending_beats.push_back(make_beat(CMD_POINT, 2'd2, '0, '0, '0, '0, '0, 8'd2, 1'b1));
    pending_beats.push_back(make_beat(CMD_POINT, 2'd1, '0, '0, '0, '0, '0, 8'd1, 1'b1));
    pending_beats.push_back(make_beat(CMD_POINT, 2'd1, '0, '0, '0, '0, '0, 8'd1, 1'b0));
    // A full scan cycle including the wrap back to phase zero.
    repeat (12) pending_beats.push_back(make_beat(CMD_TICK, 2'd3, 16'hFFFF, 8'hFF, 8'hFF,
                                                  8'hFF, 8'hFF, 8'hFF, 1'b1));
    repeat (730) pending_beats.push_back(random_display_beat());

    wait (rst_n);
    while (pending_beats.size() != 0) @(posedge clk);
    while (refresh_words_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_fail == 0 && refresh_words_due.size() == 0) begin
      $display("seven_segment_scan_driver_unit test passed");
    end else begin
      $display("seven_segment_scan_driver_unit test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("seven_segment_scan_driver_unit test failed");
    $finish;
  end

endmodule
